>>> sv/wcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcb_pkg
// Shared widths, register indexes and the window word type of the 2x2 biased
// window correlator.
// ----------------------------------------------------------------------------
package wcb_pkg;

    localparam int PIX_W         = 8;
    localparam int SUM_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int IMG_W_W       = 9;
    localparam int IMG_H_W       = 13;
    localparam int ROW_W         = 12;
    localparam int MAX_HEIGHT    = 4096;
    localparam int DEF_MAX_WIDTH = 256;
    localparam int DEF_WIDTH     = 4;
    localparam int DEF_HEIGHT    = 4;
    localparam int NUM_TAPS      = 4;

    typedef logic signed [PIX_W-1:0] t_pix;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TL  = 3'd0,
        CFG_COEF_TR  = 3'd1,
        CFG_COEF_BL  = 3'd2,
        CFG_COEF_BR  = 3'd3,
        CFG_BIAS     = 3'd4,
        CFG_WIDTH    = 3'd5,
        CFG_HEIGHT   = 3'd6
    } t_cfg_idx;

    // Window word handed along the cell chain. pix[0] is the tap that the
    // next cell consumes: upper-left, above, left, current.
    typedef struct packed {
        logic                          valid;
        logic                          last;
        logic [SUM_W-1:0]              sum;
        logic [NUM_TAPS-1:0][PIX_W-1:0] pix;
    } t_win;

endpackage

>>> sv/wcb_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcb_intf
// Valid/ready channels of the window correlator: pixel input, result output
// and configuration write.
// ----------------------------------------------------------------------------
interface wcb_pix_if;
    import wcb_pkg::*;
    logic valid;
    logic ready;
    t_pix pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface wcb_res_if;
    import wcb_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] window_sum;
    logic                    frame_last;
    modport source (output valid, output window_sum, output frame_last, input ready);
    modport sink   (input valid, input window_sum, input frame_last, output ready);
endinterface

interface wcb_cfg_if;
    import wcb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/wcb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcb_front
// Raster position counters, line buffer and window capture. Forms the 2x2
// window around each accepted pixel and starts its word with the bias.
// ----------------------------------------------------------------------------
module wcb_front #(
    parameter int MAX_WIDTH = wcb_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_accept,
    input  wcb_pkg::t_pix                 i_pixel,
    input  logic [wcb_pkg::IMG_W_W-1:0]   i_image_width,
    input  logic [wcb_pkg::IMG_H_W-1:0]   i_image_height,
    input  logic [wcb_pkg::SUM_W-1:0]     i_bias,
    output wcb_pkg::t_win                 o_win
);
    import wcb_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_pix             r_line [MAX_WIDTH];
    t_pix             r_left_pixel;
    t_pix             r_ul_pixel;

    // Stage 1: captured window of the item just accepted
    logic             r_s1_valid;
    logic             r_emit;
    logic             r_last;
    t_pix             r_above;
    t_pix             r_left;
    t_pix             r_cur;

    logic [WW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic               last_col;
    logic               last_row;

    // Saturate the geometry and find the frame edges
    always_comb begin
        w_eff = WW'(i_image_width);
        if (w_eff < WW'(2)) begin
            w_eff = WW'(2);
        end else if (w_eff > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = i_image_height;
        if (h_eff < IMG_H_W'(2)) begin
            h_eff = IMG_H_W'(2);
        end else if (h_eff > IMG_H_W'(MAX_HEIGHT)) begin
            h_eff = IMG_H_W'(MAX_HEIGHT);
        end
        last_col = WW'(r_col) >= (w_eff - WW'(1));
        last_row = IMG_H_W'(r_row) >= (h_eff - IMG_H_W'(1));
    end

    // Line buffer: read the pixel above, store the current one in its place
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_line[r_col] <= i_pixel;
            r_above       <= r_line[r_col];
            r_cur         <= i_pixel;
            r_left        <= r_left_pixel;
            r_emit        <= (r_row != '0) && (r_col != '0);
            r_last        <= last_col && last_row;
        end
    end

    // Advance position counters and neighbor pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_left_pixel <= '0;
            r_ul_pixel   <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_accept) begin
                r_left_pixel <= i_pixel;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (i_adv) begin
                // the pixel above this item is upper-left of the next
                if (r_s1_valid) begin
                    r_ul_pixel <= r_above;
                end
                r_s1_valid <= i_accept;
            end
        end
    end

    // Start the window word
    always_comb begin
        o_win.valid  = r_s1_valid && r_emit;
        o_win.last   = r_last;
        o_win.sum    = i_bias;
        o_win.pix[0] = r_ul_pixel;
        o_win.pix[1] = r_above;
        o_win.pix[2] = r_left;
        o_win.pix[3] = r_cur;
    end

endmodule

>>> sv/wcb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcb_cell
// One multiply-accumulate cell of the chain: adds coefficient times the head
// tap to the running sum and hands the word on with the taps shifted down.
// ----------------------------------------------------------------------------
module wcb_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  wcb_pkg::t_pix i_coef,
    input  wcb_pkg::t_win i_win,
    output wcb_pkg::t_win o_win
);
    import wcb_pkg::*;

    localparam int PROD_W = 2 * PIX_W;

    logic signed [PROD_W-1:0] prod;
    t_win                     n_win;
    t_win                     r_win;

    // Multiply the head tap, accumulate, shift the remaining taps
    always_comb begin
        prod        = PROD_W'(i_coef) * PROD_W'($signed(i_win.pix[0]));
        n_win.valid = i_win.valid;
        n_win.last  = i_win.last;
        n_win.sum   = i_win.sum + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
        for (int i = 0; i < NUM_TAPS - 1; i++) begin
            n_win.pix[i] = i_win.pix[i+1];
        end
        n_win.pix[NUM_TAPS-1] = '0;
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.valid <= 1'b0;
        end else if (i_adv) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule

>>> sv/window_correlation_2x2_bias.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_correlation_2x2_bias
// 2x2 valid-mode window correlation with bias on a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one signed 8-bit pixel per clock in raster order and, for every 2x2
// window that lies inside the frame, returns bias plus the weighted window sum,
// wrapped to 32 bits; frame_last marks the window ending at the frame's last
// pixel. The accepting edge of a pixel loads the line buffer read stage, then
// each of four chained multiply-accumulate cells registers its word in turn,
// the last of which is the output register. Throughput is one pixel per clock;
// the whole pipeline holds while the output word is not taken, which is what
// drops input ready. The first row and first column of each frame give no
// result. Configuration writes are taken at any time but must only be issued
// while the block is idle; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
module window_correlation_2x2_bias #(
    parameter int MAX_WIDTH = wcb_pkg::DEF_MAX_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wcb_pix_if.sink   i_pix,
    wcb_cfg_if.sink   i_cfg,
    wcb_res_if.source o_res
);
    import wcb_pkg::*;

    t_pix               r_coef [NUM_TAPS];
    logic [SUM_W-1:0]   r_bias;
    logic [IMG_W_W-1:0] r_image_width;
    logic [IMG_H_W-1:0] r_image_height;

    t_win chain [NUM_TAPS+1];
    logic adv;
    logic accept;

    // Pipeline moves whenever the output register is free or being taken
    assign adv         = !chain[NUM_TAPS].valid || o_res.ready;
    assign i_pix.ready = adv;
    assign accept      = i_pix.valid && adv;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_coef[i] <= '0;
            end
            r_bias         <= '0;
            r_image_width  <= IMG_W_W'(DEF_WIDTH);
            r_image_height <= IMG_H_W'(DEF_HEIGHT);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_COEF_TL: r_coef[0]      <= i_cfg.data[PIX_W-1:0];
                CFG_COEF_TR: r_coef[1]      <= i_cfg.data[PIX_W-1:0];
                CFG_COEF_BL: r_coef[2]      <= i_cfg.data[PIX_W-1:0];
                CFG_COEF_BR: r_coef[3]      <= i_cfg.data[PIX_W-1:0];
                CFG_BIAS:    r_bias         <= i_cfg.data[SUM_W-1:0];
                CFG_WIDTH:   r_image_width  <= i_cfg.data[IMG_W_W-1:0];
                CFG_HEIGHT:  r_image_height <= i_cfg.data[IMG_H_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window capture
    wcb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_accept       (accept),
        .i_pixel        (i_pix.pixel),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_bias         (r_bias),
        .o_win          (chain[0])
    );

    // Multiply-accumulate chain, one cell per tap
    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_cell
        wcb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_coef  (r_coef[g]),
            .i_win   (chain[g]),
            .o_win   (chain[g+1])
        );
    end

    // Output word straight from the last cell register
    assign o_res.valid      = chain[NUM_TAPS].valid;
    assign o_res.window_sum = chain[NUM_TAPS].sum;
    assign o_res.frame_last = chain[NUM_TAPS].last;

endmodule
